// ===== hdl/crt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg
// Shared codes, field widths and reset values of the confirmable message
// retransmitter.
// ----------------------------------------------------------------------------
package crt_pkg;

  // field widths of the channels
  localparam int unsigned OP_W       = 2;
  localparam int unsigned MSG_ID_W   = 16;
  localparam int unsigned EVT_W      = 3;
  localparam int unsigned RETRY_W    = 4;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // configuration register widths
  localparam int unsigned ACK_TO_W   = 24;
  localparam int unsigned FACTOR_W   = 6;
  localparam int unsigned LFSR_W     = 16;

  // timeout draw datapath widths
  localparam int unsigned MUL_A_W    = 28;
  localparam int unsigned MUL_B_W    = 16;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned HI_W       = 27;
  localparam int unsigned HI_LSB     = 3;
  localparam int unsigned SCALE_LSB  = 16;
  localparam int unsigned DRAW_W     = 29;
  localparam int unsigned WIDE_W     = 64;

  // galois feedback mask
  localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

  // register reset values
  localparam logic [ACK_TO_W-1:0] ACK_TO_RST   = 24'd2000;
  localparam logic [FACTOR_W-1:0] FACTOR_RST   = 6'd12;
  localparam logic [RETRY_W-1:0]  MAX_RETX_RST = 4'd4;
  localparam logic [MSG_ID_W-1:0] START_ID_RST = 16'd0;
  localparam logic [LFSR_W-1:0]   SEED_RST     = 16'd44257;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_ACK   = 2'd2,
    OP_OTHER = 2'd3
  } op_e;

  typedef enum logic [EVT_W-1:0] {
    EV_NONE     = 3'd0,
    EV_FIRST    = 3'd1,
    EV_RETX     = 3'd2,
    EV_GAVE_UP  = 3'd3,
    EV_ACKED    = 3'd4,
    EV_WRONG_ID = 3'd5,
    EV_NOT_ACK  = 3'd6
  } evt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACK_TIMEOUT = 3'd0,
    CFG_FACTOR      = 3'd1,
    CFG_MAX_RETX    = 3'd2,
    CFG_START_ID    = 3'd3,
    CFG_LFSR_SEED   = 3'd4
  } cfg_idx_e;

endpackage

// ===== hdl/crt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_if
// Handshake channels of the retransmitter: event input, result output and
// configuration write.
// ----------------------------------------------------------------------------

// event input channel
interface crt_in_if;
  logic                        valid;
  logic                        ready;
  logic [crt_pkg::OP_W-1:0]     op;
  logic [crt_pkg::MSG_ID_W-1:0] ack_id;

  modport source (output valid, output op, output ack_id, input ready);
  modport sink   (input valid, input op, input ack_id, output ready);
endinterface

// result output channel
interface crt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        send_con;
  logic [crt_pkg::MSG_ID_W-1:0] message_id;
  logic [crt_pkg::EVT_W-1:0]    event_code;
  logic [crt_pkg::RETRY_W-1:0]  retry_count;
  logic [crt_pkg::CNT_W-1:0]    timeout_ticks;
  logic [crt_pkg::CNT_W-1:0]    rtt_ticks;
  logic [crt_pkg::CNT_W-1:0]    sent_total;
  logic [crt_pkg::CNT_W-1:0]    ack_total;

  modport source (output valid, output send_con, output message_id, output event_code,
                  output retry_count, output timeout_ticks, output rtt_ticks,
                  output sent_total, output ack_total, input ready);
  modport sink   (input valid, input send_con, input message_id, input event_code,
                  input retry_count, input timeout_ticks, input rtt_ticks,
                  input sent_total, input ack_total, output ready);
endinterface

// configuration write channel
interface crt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [crt_pkg::CFG_IDX_W-1:0]  index;
  logic [crt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/coap_confirmable_retransmitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_confirmable_retransmitter
// Sender side of confirmable messaging with randomised exponential backoff.
// A small sequencer reuses one 28x16 multiplier for the timeout draw.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                           beat when
//  in_i     in   op, ack_id                                        valid & ready
//  out_o    out  send_con, message_id, event_code, retry_count,    valid & ready
//                timeout_ticks, rtt_ticks, sent_total, ack_total
//  cfg_i    in   index, data                                       valid & ready
//
//  result valid after S_EXEC, or after S_EXEC, S_MUL1, S_MUL2 and S_ARM when a new
//  message ID draws a timeout (two passes through the shared multiplier)
//  one event at a time: in_i is ready only while the sequencer is idle
//  the result is held on out_o until taken; a stalled output holds the block
//  reset is asynchronous and needs no clearing pass; cfg_i is always ready
//
module coap_confirmable_retransmitter #(
  parameter int unsigned TIMER_WIDTH = 32,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crt_in_if.sink     in_i,
  crt_out_if.source  out_o,
  crt_cfg_if.sink    cfg_i
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MUL1 = 6'b000100,
    S_MUL2 = 6'b001000,
    S_ARM  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q;

  // configuration registers
  logic [crt_pkg::ACK_TO_W-1:0] ack_to_q;
  logic [crt_pkg::FACTOR_W-1:0] factor_q;
  logic [crt_pkg::RETRY_W-1:0]  max_retx_q;

  // protocol state
  logic                         running_q;
  logic [ID_WIDTH-1:0]          current_id_q;
  logic [crt_pkg::RETRY_W-1:0]  retries_q;
  logic [TIMER_WIDTH-1:0]       timeout_q;
  logic [TIMER_WIDTH-1:0]       countdown_q;
  logic                         armed_q;
  logic [TIMER_WIDTH-1:0]       elapsed_q;
  logic [crt_pkg::CNT_W-1:0]    sent_q;
  logic [crt_pkg::CNT_W-1:0]    acked_q;
  logic [crt_pkg::LFSR_W-1:0]   lfsr_q;

  // captured beat and result payload
  crt_pkg::op_e                 op_q;
  logic [crt_pkg::MSG_ID_W-1:0] ack_id_q;
  logic                         send_q;
  crt_pkg::evt_e                evt_q;
  logic [TIMER_WIDTH-1:0]       rtt_q;
  logic [crt_pkg::PROD_W-1:0]   prod_q;

  logic in_beat;
  logic out_beat;
  logic cfg_beat;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = (state_q == S_OUT);
  assign in_beat  = in_i.valid & in_i.ready;
  assign out_beat = out_o.valid & out_o.ready;
  assign cfg_beat = cfg_i.valid & cfg_i.ready;

  // helper values for the event step
  logic [TIMER_WIDTH-1:0]         doubled;
  logic [TIMER_WIDTH-1:0]         elapsed_inc;
  logic [crt_pkg::RETRY_W:0]      retry_next;
  logic [ID_WIDTH-1:0]            id_inc;
  logic [ID_WIDTH-1:0]            ack_id_cmp;
  logic [crt_pkg::LFSR_W-1:0]     lfsr_fix;
  logic [crt_pkg::LFSR_W-1:0]     lfsr_step;

  always_comb begin
    doubled     = timeout_q[TIMER_WIDTH-1] ? '1 : {timeout_q[TIMER_WIDTH-2:0], 1'b0};
    elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
    retry_next  = {1'b0, retries_q} + 1'b1;
    id_inc      = current_id_q + 1'b1;
    ack_id_cmp  = ID_WIDTH'(ack_id_q);
    lfsr_fix    = (lfsr_q == '0) ? crt_pkg::LFSR_W'(1) : lfsr_q;
    lfsr_step   = lfsr_fix[0] ? ((lfsr_fix >> 1) ^ crt_pkg::LFSR_MASK) : (lfsr_fix >> 1);
  end

  // shared multiplier: scale of the upper bound, then the random pick
  logic [crt_pkg::MUL_A_W-1:0] mul_a;
  logic [crt_pkg::MUL_B_W-1:0] mul_b;
  logic [crt_pkg::PROD_W-1:0]  prod_d;
  logic [crt_pkg::HI_W-1:0]    hi_raw;
  logic [crt_pkg::HI_W-1:0]    hi_clamp;
  logic [crt_pkg::MUL_A_W-1:0] span;
  logic [crt_pkg::DRAW_W-1:0]  draw_sum;
  logic [TIMER_WIDTH-1:0]      draw_tmr;

  always_comb begin
    hi_raw   = prod_q[crt_pkg::HI_LSB +: crt_pkg::HI_W];
    hi_clamp = (hi_raw < crt_pkg::HI_W'(ack_to_q)) ? crt_pkg::HI_W'(ack_to_q) : hi_raw;
    span     = crt_pkg::MUL_A_W'(hi_clamp) - crt_pkg::MUL_A_W'(ack_to_q) + 1'b1;
    draw_sum = crt_pkg::DRAW_W'(ack_to_q)
             + crt_pkg::DRAW_W'(prod_q[crt_pkg::PROD_W-1:crt_pkg::SCALE_LSB]);
    draw_tmr = (crt_pkg::WIDE_W'(draw_sum) > crt_pkg::WIDE_W'({TIMER_WIDTH{1'b1}}))
             ? '1 : TIMER_WIDTH'(draw_sum);
    unique case (state_q)
      S_MUL1: begin
        mul_a = crt_pkg::MUL_A_W'(ack_to_q);
        mul_b = crt_pkg::MUL_B_W'(factor_q);
      end
      S_MUL2: begin
        mul_a = span;
        mul_b = lfsr_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = crt_pkg::PROD_W'(mul_a) * crt_pkg::PROD_W'(mul_b);
  end

  // payload registers: captured beat, product and result fields
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q     <= crt_pkg::op_e'(in_i.op);
      ack_id_q <= in_i.ack_id;
    end
    if (state_q == S_MUL1 || state_q == S_MUL2) begin
      prod_q <= prod_d;
    end
    if (state_q == S_EXEC) begin
      send_q <= 1'b0;
      evt_q  <= crt_pkg::EV_NONE;
      rtt_q  <= '0;
      unique case (op_q)
        crt_pkg::OP_START: begin
          if (!running_q) begin
            send_q <= 1'b1;
            evt_q  <= crt_pkg::EV_FIRST;
          end
        end
        crt_pkg::OP_TICK: begin
          if (running_q && armed_q && countdown_q <= TIMER_WIDTH'(1)) begin
            send_q <= 1'b1;
            evt_q  <= (retry_next <= {1'b0, max_retx_q}) ? crt_pkg::EV_RETX
                                                          : crt_pkg::EV_GAVE_UP;
          end
        end
        crt_pkg::OP_ACK: begin
          if (running_q) begin
            send_q <= 1'b1;
            if (ack_id_cmp == current_id_q) begin
              evt_q <= crt_pkg::EV_ACKED;
              rtt_q <= elapsed_q;
            end else begin
              evt_q <= crt_pkg::EV_WRONG_ID;
            end
          end
        end
        crt_pkg::OP_OTHER: begin
          evt_q <= crt_pkg::EV_NOT_ACK;
        end
      endcase
    end
  end

  // sequencer, configuration and protocol state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ack_to_q     <= crt_pkg::ACK_TO_RST;
      factor_q     <= crt_pkg::FACTOR_RST;
      max_retx_q   <= crt_pkg::MAX_RETX_RST;
      running_q    <= 1'b0;
      current_id_q <= ID_WIDTH'(crt_pkg::START_ID_RST);
      retries_q    <= '0;
      timeout_q    <= '0;
      countdown_q  <= '0;
      armed_q      <= 1'b0;
      elapsed_q    <= '0;
      sent_q       <= '0;
      acked_q      <= '0;
      lfsr_q       <= crt_pkg::SEED_RST;
    end else begin
      // register writes, expected only between events
      if (cfg_beat) begin
        unique case (cfg_i.index)
          crt_pkg::CFG_ACK_TIMEOUT: ack_to_q   <= cfg_i.data[crt_pkg::ACK_TO_W-1:0];
          crt_pkg::CFG_FACTOR:      factor_q   <= cfg_i.data[crt_pkg::FACTOR_W-1:0];
          crt_pkg::CFG_MAX_RETX:    max_retx_q <= cfg_i.data[crt_pkg::RETRY_W-1:0];
          crt_pkg::CFG_START_ID: begin
            if (!running_q) begin
              current_id_q <= ID_WIDTH'(cfg_i.data[crt_pkg::MSG_ID_W-1:0]);
            end
          end
          crt_pkg::CFG_LFSR_SEED:   lfsr_q     <= cfg_i.data[crt_pkg::LFSR_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_beat) state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_OUT;
          unique case (op_q)
            crt_pkg::OP_START: begin
              if (!running_q) begin
                running_q <= 1'b1;
                sent_q    <= sent_q + 1'b1;
                elapsed_q <= '0;
                retries_q <= '0;
                state_q   <= S_MUL1;
              end
            end
            crt_pkg::OP_TICK: begin
              if (running_q && armed_q) begin
                elapsed_q <= elapsed_inc;
                if (countdown_q <= TIMER_WIDTH'(1)) begin
                  sent_q <= sent_q + 1'b1;
                  if (retry_next <= {1'b0, max_retx_q}) begin
                    retries_q   <= retry_next[crt_pkg::RETRY_W-1:0];
                    timeout_q   <= doubled;
                    countdown_q <= doubled;
                  end else begin
                    current_id_q <= id_inc;
                    elapsed_q    <= '0;
                    retries_q    <= '0;
                    state_q      <= S_MUL1;
                  end
                end else begin
                  countdown_q <= countdown_q - 1'b1;
                end
              end
            end
            crt_pkg::OP_ACK: begin
              if (running_q) begin
                sent_q <= sent_q + 1'b1;
                if (ack_id_cmp == current_id_q) begin
                  acked_q      <= acked_q + 1'b1;
                  current_id_q <= id_inc;
                  elapsed_q    <= '0;
                  retries_q    <= '0;
                  state_q      <= S_MUL1;
                end else begin
                  timeout_q   <= doubled;
                  countdown_q <= doubled;
                  armed_q     <= 1'b1;
                end
              end
            end
            crt_pkg::OP_OTHER: ;
          endcase
        end
        // step the generator while the upper bound is scaled
        S_MUL1: begin
          lfsr_q  <= lfsr_step;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          state_q <= S_ARM;
        end
        S_ARM: begin
          timeout_q   <= draw_tmr;
          countdown_q <= draw_tmr;
          armed_q     <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (out_beat) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result fields straight from the state registers
  assign out_o.send_con      = send_q;
  assign out_o.message_id    = crt_pkg::MSG_ID_W'(current_id_q);
  assign out_o.event_code    = evt_q;
  assign out_o.retry_count   = retries_q;
  assign out_o.timeout_ticks = crt_pkg::CNT_W'(timeout_q);
  assign out_o.rtt_ticks     = crt_pkg::CNT_W'(rtt_q);
  assign out_o.sent_total    = sent_q;
  assign out_o.ack_total     = acked_q;

  // the sent counter only moves while an event is evaluated
  a_sent_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(sent_q) |-> $past(state_q == S_EXEC))
    else $error("sent counter changed outside event evaluation");

  // arming loads countdown and timeout together
  a_arm_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ARM) |=> (armed_q && countdown_q == timeout_q))
    else $error("timer not armed consistently");

  // a sent message carries a sending event code
  a_send_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.send_con) |->
      (evt_q != crt_pkg::EV_NONE && evt_q != crt_pkg::EV_NOT_ACK))
    else $error("send flagged with non-sending event");

  // input and output are never open in the same cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while a result is pending");

endmodule

// ===== tb/sv/coap_confirmable_retransmitter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_confirmable_retransmitter_tb
// Self-checking bench for the confirmable message retransmitter. A directed
// table covers reset behaviour, ID wrap, give-up, wrong-ID resends, timeout
// saturation, a zero timeout and a zero LFSR seed. Random phases with fresh
// register settings follow. Every result beat is compared field by field
// with the table's expected result or an in-bench model of the backoff
// sequencer, under random stalls on both channels.
// ----------------------------------------------------------------------------
module coap_confirmable_retransmitter_tb;

  localparam int unsigned LIMIT_CYCLES    = 400000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned RAND_PHASES     = 6;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned MAX_PRINTS      = 100;
  localparam logic [63:0] TIMER_MAX       = 64'hFFFF_FFFF;

  // register indexes outside the map, written to check they are ignored
  localparam logic [crt_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [crt_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic                         send_con;
    logic [crt_pkg::MSG_ID_W-1:0] msg_id;
    crt_pkg::evt_e                evt;
    logic [crt_pkg::RETRY_W-1:0]  retry;
    logic [crt_pkg::CNT_W-1:0]    timeout;
    logic [crt_pkg::CNT_W-1:0]    rtt;
    logic [crt_pkg::CNT_W-1:0]    sent;
    logic [crt_pkg::CNT_W-1:0]    acked;
  } con_result_t;

  typedef enum logic {ROW_EVENT, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                      kind;
    logic [crt_pkg::CFG_IDX_W-1:0]  idx;
    logic [crt_pkg::CFG_DATA_W-1:0] data;
    crt_pkg::op_e                   op;
    logic [crt_pkg::MSG_ID_W-1:0]   aid;
    bit                             typed;
    con_result_t                    res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  crt_in_if  in_if ();
  crt_out_if out_if ();
  crt_cfg_if cfg_if ();

  coap_confirmable_retransmitter u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #2 clk = ~clk;

  // model registers
  logic [crt_pkg::ACK_TO_W-1:0] cf_ack_to;
  logic [crt_pkg::FACTOR_W-1:0] cf_factor;
  logic [crt_pkg::RETRY_W-1:0]  cf_max_retx;
  logic [crt_pkg::MSG_ID_W-1:0] cf_start_id;
  logic [crt_pkg::LFSR_W-1:0]   cf_seed;

  // model state
  logic                         bo_running;
  logic [crt_pkg::MSG_ID_W-1:0] bo_cur_id;
  logic [crt_pkg::RETRY_W-1:0]  bo_retries;
  logic [crt_pkg::CNT_W-1:0]    bo_timeout;
  logic [crt_pkg::CNT_W-1:0]    bo_countdown;
  logic                         bo_armed;
  logic [crt_pkg::CNT_W-1:0]    bo_elapsed;
  logic [crt_pkg::CNT_W-1:0]    bo_sent;
  logic [crt_pkg::CNT_W-1:0]    bo_acked;
  logic [crt_pkg::LFSR_W-1:0]   bo_lfsr;

  con_result_t  pending_res_q[$];
  stim_row_t    stim_tab[$];
  int unsigned  err_cnt     = 0;
  int unsigned  res_checked = 0;
  int unsigned  ev_driven   = 0;
  int unsigned  sat_seen    = 0;
  int unsigned  evt_seen[8];
  int unsigned  cycle_cnt   = 0;
  int unsigned  stall_left  = 0;
  bit           idle_on     = 1'b1;

  // new message id: step the lfsr and draw the first timeout
  function automatic void send_fresh_id();
    logic [63:0] lo, hi, span, v;
    lo = 64'(cf_ack_to);
    hi = (lo * 64'(cf_factor)) >> 3;
    if (bo_lfsr == '0) bo_lfsr = 16'd1;
    if (bo_lfsr[0]) bo_lfsr = (bo_lfsr >> 1) ^ crt_pkg::LFSR_MASK;
    else bo_lfsr = bo_lfsr >> 1;
    if (hi < lo) hi = lo;
    span = hi - lo + 64'd1;
    v = lo + ((64'(bo_lfsr) * span) >> 16);
    if (v > TIMER_MAX) v = TIMER_MAX;
    bo_sent++;
    bo_elapsed   = '0;
    bo_retries   = '0;
    bo_timeout   = v[crt_pkg::CNT_W-1:0];
    bo_countdown = v[crt_pkg::CNT_W-1:0];
    bo_armed     = 1'b1;
  endfunction

  // same id again with the timeout doubled, saturating
  function automatic void resend_doubled();
    logic [63:0] t;
    t = 64'(bo_timeout) << 1;
    if (t > TIMER_MAX) t = TIMER_MAX;
    bo_sent++;
    bo_timeout   = t[crt_pkg::CNT_W-1:0];
    bo_countdown = t[crt_pkg::CNT_W-1:0];
    bo_armed     = 1'b1;
  endfunction

  // advance the model by one event and return the result it gives
  function automatic con_result_t predict_backoff(crt_pkg::op_e op,
                                                  logic [crt_pkg::MSG_ID_W-1:0] aid);
    con_result_t                 r;
    logic                        snd;
    crt_pkg::evt_e               ev;
    logic [crt_pkg::CNT_W-1:0]   rtt;
    logic [crt_pkg::RETRY_W:0]   nxt;
    snd = 1'b0;
    ev  = crt_pkg::EV_NONE;
    rtt = '0;
    case (op)
      crt_pkg::OP_START: begin
        if (!bo_running) begin
          bo_running = 1'b1;
          send_fresh_id();
          snd = 1'b1;
          ev  = crt_pkg::EV_FIRST;
        end
      end
      crt_pkg::OP_TICK: begin
        if (bo_running && bo_armed) begin
          if (bo_elapsed != '1) bo_elapsed++;
          if (bo_countdown <= 1) begin
            nxt = {1'b0, bo_retries} + 1'b1;
            if (nxt <= {1'b0, cf_max_retx}) begin
              bo_retries = nxt[crt_pkg::RETRY_W-1:0];
              resend_doubled();
              ev = crt_pkg::EV_RETX;
            end else begin
              bo_cur_id++;
              send_fresh_id();
              ev = crt_pkg::EV_GAVE_UP;
            end
            snd = 1'b1;
          end else begin
            bo_countdown--;
          end
        end
      end
      crt_pkg::OP_ACK: begin
        if (bo_running) begin
          if (aid == bo_cur_id) begin
            bo_acked++;
            rtt = bo_elapsed;
            bo_cur_id++;
            send_fresh_id();
            ev = crt_pkg::EV_ACKED;
          end else begin
            resend_doubled();
            ev = crt_pkg::EV_WRONG_ID;
          end
          snd = 1'b1;
        end
      end
      default: ev = crt_pkg::EV_NOT_ACK;
    endcase
    r.send_con = snd;
    r.msg_id   = bo_cur_id;
    r.evt      = ev;
    r.retry    = bo_retries;
    r.timeout  = bo_timeout;
    r.rtt      = rtt;
    r.sent     = bo_sent;
    r.acked    = bo_acked;
    return r;
  endfunction

  function automatic con_result_t con_res(logic s, logic [crt_pkg::MSG_ID_W-1:0] id,
                                          crt_pkg::evt_e ev,
                                          logic [crt_pkg::RETRY_W-1:0] rc,
                                          logic [crt_pkg::CNT_W-1:0] to,
                                          logic [crt_pkg::CNT_W-1:0] rtt,
                                          logic [crt_pkg::CNT_W-1:0] sent,
                                          logic [crt_pkg::CNT_W-1:0] ack);
    con_result_t r;
    r = '{send_con: s, msg_id: id, evt: ev, retry: rc, timeout: to, rtt: rtt,
          sent: sent, acked: ack};
    return r;
  endfunction

  function automatic void add_event(crt_pkg::op_e op, logic [crt_pkg::MSG_ID_W-1:0] aid);
    stim_row_t row;
    row = '{kind: ROW_EVENT, idx: '0, data: '0, op: op, aid: aid, typed: 1'b0, res: '0};
    stim_tab.push_back(row);
  endfunction

  function automatic void add_event_res(crt_pkg::op_e op,
                                        logic [crt_pkg::MSG_ID_W-1:0] aid,
                                        con_result_t r);
    stim_row_t row;
    row = '{kind: ROW_EVENT, idx: '0, data: '0, op: op, aid: aid, typed: 1'b1, res: r};
    stim_tab.push_back(row);
  endfunction

  function automatic void add_cfg(logic [crt_pkg::CFG_IDX_W-1:0] idx,
                                  logic [crt_pkg::CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{kind: ROW_CFG, idx: idx, data: data, op: crt_pkg::OP_OTHER, aid: '0,
            typed: 1'b0, res: '0};
    stim_tab.push_back(row);
  endfunction

  task automatic report_mismatch(string msg);
    if (err_cnt < MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [crt_pkg::CNT_W-1:0] got,
                             logic [crt_pkg::CNT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // one register write beat; valid stays up for a following write
  task automatic cfg_write(logic [crt_pkg::CFG_IDX_W-1:0] idx,
                           logic [crt_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      crt_pkg::CFG_ACK_TIMEOUT: cf_ack_to   = data[crt_pkg::ACK_TO_W-1:0];
      crt_pkg::CFG_FACTOR:      cf_factor   = data[crt_pkg::FACTOR_W-1:0];
      crt_pkg::CFG_MAX_RETX:    cf_max_retx = data[crt_pkg::RETRY_W-1:0];
      crt_pkg::CFG_START_ID: begin
        cf_start_id = data[crt_pkg::MSG_ID_W-1:0];
        if (!bo_running) bo_cur_id = cf_start_id;
      end
      crt_pkg::CFG_LFSR_SEED: begin
        cf_seed = data[crt_pkg::LFSR_W-1:0];
        bo_lfsr = cf_seed;
      end
      default: ;
    endcase
  endtask

  // one event beat; the expectation is queued at acceptance
  task automatic drive_event(crt_pkg::op_e op, logic [crt_pkg::MSG_ID_W-1:0] aid,
                             bit typed, con_result_t typed_res);
    con_result_t r;
    in_if.valid  <= 1'b1;
    in_if.op     <= op;
    in_if.ack_id <= aid;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    r = predict_backoff(op, aid);
    if (typed) r = typed_res;
    pending_res_q.push_back(r);
    ev_driven++;
    evt_seen[int'(r.evt)]++;
    if (r.timeout == '1) sat_seen++;
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // drop valid, wait for the last result, then let the pipeline settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cycle counter
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             pending_res_q.size());
    $display("tb: failure");
    $finish;
  end

  // result ready with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(1, 8);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // compare every result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    con_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_res_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_res_q.pop_front();
        res_checked++;
        check_field("send_con", 32'(out_if.send_con), 32'(want.send_con));
        check_field("message_id", 32'(out_if.message_id), 32'(want.msg_id));
        check_field("event_code", 32'(out_if.event_code), 32'(want.evt));
        check_field("retry_count", 32'(out_if.retry_count), 32'(want.retry));
        check_field("timeout_ticks", out_if.timeout_ticks, want.timeout);
        check_field("rtt_ticks", out_if.rtt_ticks, want.rtt);
        check_field("sent_total", out_if.sent_total, want.sent);
        check_field("ack_total", out_if.ack_total, want.acked);
      end
    end
  end

  initial begin
    crt_pkg::op_e                 op;
    logic [crt_pkg::MSG_ID_W-1:0] aid;
    int unsigned                  pick;
    bit                           cfg_open;

    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.op      = crt_pkg::OP_TICK;
    in_if.ack_id  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = crt_pkg::CFG_ACK_TIMEOUT;
    cfg_if.data   = '0;
    cfg_open      = 1'b0;
    foreach (evt_seen[i]) evt_seen[i] = 0;

    // model at reset
    cf_ack_to    = crt_pkg::ACK_TO_RST;
    cf_factor    = crt_pkg::FACTOR_RST;
    cf_max_retx  = crt_pkg::MAX_RETX_RST;
    cf_start_id  = crt_pkg::START_ID_RST;
    cf_seed      = crt_pkg::SEED_RST;
    bo_running   = 1'b0;
    bo_cur_id    = crt_pkg::START_ID_RST;
    bo_retries   = '0;
    bo_timeout   = '0;
    bo_countdown = '0;
    bo_armed     = 1'b0;
    bo_elapsed   = '0;
    bo_sent      = '0;
    bo_acked     = '0;
    bo_lfsr      = crt_pkg::SEED_RST;

    // events before start are ignored, other messages always flagged
    add_event_res(crt_pkg::OP_TICK, 16'h0000,
                  con_res(0, 16'h0000, crt_pkg::EV_NONE, 0, 0, 0, 0, 0));
    add_event_res(crt_pkg::OP_ACK, 16'h0000,
                  con_res(0, 16'h0000, crt_pkg::EV_NONE, 0, 0, 0, 0, 0));
    add_event_res(crt_pkg::OP_OTHER, 16'hFFFF,
                  con_res(0, 16'h0000, crt_pkg::EV_NOT_ACK, 0, 0, 0, 0, 0));
    // fixed one-tick timeout, no retries, id at the top of its range
    add_cfg(crt_pkg::CFG_ACK_TIMEOUT, 24'd1);
    add_cfg(crt_pkg::CFG_FACTOR, 24'd8);
    add_cfg(crt_pkg::CFG_MAX_RETX, 24'd0);
    add_cfg(crt_pkg::CFG_START_ID, 24'h00FFFF);
    add_cfg(crt_pkg::CFG_LFSR_SEED, 24'd1);
    add_cfg(CFG_UNUSED_LO, 24'hFFFFFF);
    add_event_res(crt_pkg::OP_START, 16'h1234,
                  con_res(1, 16'hFFFF, crt_pkg::EV_FIRST, 0, 1, 0, 1, 0));
    // start while running does nothing
    add_event_res(crt_pkg::OP_START, 16'h0000,
                  con_res(0, 16'hFFFF, crt_pkg::EV_NONE, 0, 1, 0, 1, 0));
    // expiry with no retries left gives up and wraps the id
    add_event_res(crt_pkg::OP_TICK, 16'h0000,
                  con_res(1, 16'h0000, crt_pkg::EV_GAVE_UP, 0, 1, 0, 2, 0));
    add_event_res(crt_pkg::OP_ACK, 16'h0000,
                  con_res(1, 16'h0001, crt_pkg::EV_ACKED, 0, 1, 0, 3, 1));
    add_event_res(crt_pkg::OP_ACK, 16'hFFFF,
                  con_res(1, 16'h0001, crt_pkg::EV_WRONG_ID, 0, 2, 0, 4, 1));
    add_event_res(crt_pkg::OP_OTHER, 16'hA5A5,
                  con_res(0, 16'h0001, crt_pkg::EV_NOT_ACK, 0, 2, 0, 4, 1));
    // largest timeout and factor, zero seed, then doubling into saturation
    add_cfg(crt_pkg::CFG_ACK_TIMEOUT, 24'hFFFFFF);
    add_cfg(crt_pkg::CFG_FACTOR, 24'd63);
    add_cfg(crt_pkg::CFG_MAX_RETX, 24'd15);
    add_cfg(crt_pkg::CFG_LFSR_SEED, 24'd0);
    add_event(crt_pkg::OP_ACK, 16'h0001);
    repeat (8) add_event(crt_pkg::OP_ACK, 16'hFFFF);
    // zero timeout and a factor below one: expiry on every tick
    add_cfg(crt_pkg::CFG_ACK_TIMEOUT, 24'd0);
    add_cfg(crt_pkg::CFG_FACTOR, 24'd0);
    add_cfg(crt_pkg::CFG_MAX_RETX, 24'd2);
    add_cfg(CFG_UNUSED_HI, 24'h000000);
    add_event(crt_pkg::OP_ACK, 16'h0002);
    repeat (4) add_event(crt_pkg::OP_TICK, 16'h5A5A);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == ROW_CFG) begin
        if (!cfg_open) begin
          wait_idle();
          cfg_open = 1'b1;
        end
        cfg_write(stim_tab[i].idx, stim_tab[i].data);
      end else begin
        if (cfg_open) begin
          cfg_if.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        maybe_idle();
        drive_event(stim_tab[i].op, stim_tab[i].aid, stim_tab[i].typed, stim_tab[i].res);
      end
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      cfg_write(crt_pkg::CFG_ACK_TIMEOUT,
                ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 12)));
      cfg_write(crt_pkg::CFG_FACTOR, 24'($urandom));
      cfg_write(crt_pkg::CFG_MAX_RETX, 24'($urandom));
      cfg_write(crt_pkg::CFG_START_ID, 24'($urandom));
      cfg_write(crt_pkg::CFG_LFSR_SEED,
                ($urandom_range(0, 7) == 0) ? 24'($urandom & 32'hFF0000) : 24'($urandom));
      if ($urandom_range(0, 2) == 0)
        cfg_write(CFG_UNUSED_LO + 3'($urandom_range(0, 2)), 24'($urandom));
      cfg_if.valid <= 1'b0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == RAND_PHASES - 1) idle_on = 1'b0;
        else if (k % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 99);
        aid  = 16'($urandom);
        if (pick < 55) begin
          op = crt_pkg::OP_TICK;
        end else if (pick < 72) begin
          op  = crt_pkg::OP_ACK;
          aid = bo_cur_id;
        end else if (pick < 80) begin
          op  = crt_pkg::OP_ACK;
          aid = bo_cur_id ^ (16'd1 << $urandom_range(0, 15));
        end else if (pick < 86) begin
          op = crt_pkg::OP_ACK;
        end else if (pick < 94) begin
          op = crt_pkg::OP_OTHER;
        end else begin
          op = crt_pkg::OP_START;
        end
        maybe_idle();
        drive_event(op, aid, 1'b0, '0);
      end
    end

    wait_idle();
    $display("covered %0d events, %0d results checked, %0d with saturated timeout",
             ev_driven, res_checked, sat_seen);
    $display("events: first %0d retx %0d gave-up %0d acked %0d wrong-id %0d other %0d",
             evt_seen[crt_pkg::EV_FIRST], evt_seen[crt_pkg::EV_RETX],
             evt_seen[crt_pkg::EV_GAVE_UP], evt_seen[crt_pkg::EV_ACKED],
             evt_seen[crt_pkg::EV_WRONG_ID], evt_seen[crt_pkg::EV_NOT_ACK]);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/crt_pkg.sv
hdl/crt_if.sv
hdl/coap_confirmable_retransmitter.sv
tb/sv/coap_confirmable_retransmitter_tb.sv
